FILE: design/ssi_pkg.sv
// Shared constants and types for the segment intersection pipeline.
package ssi_pkg;

    // Coordinates wider than this are reduced to their low bits.
    localparam int CW_LIMIT = 30;

    // Lanes of the shared multiply-divide pipeline.
    localparam int NUM_LANES = 3;
    localparam int LANE_X    = 0;
    localparam int LANE_Y    = 1;
    localparam int LANE_T    = 2;

    typedef struct packed {
        logic hit;
        logic neg_x;
        logic neg_y;
    } t_flags;

endpackage

FILE: design/ssi_front.sv
// Front end: differences, cross products, sums and hit test in four register stages.
module ssi_front #(
    parameter int COORD_BITS = 16,
    parameter int CW         = 16
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COORD_BITS-1:0]  i_ray_start_x,
    input  logic signed [COORD_BITS-1:0]  i_ray_start_y,
    input  logic signed [COORD_BITS-1:0]  i_ray_end_x,
    input  logic signed [COORD_BITS-1:0]  i_ray_end_y,
    input  logic signed [COORD_BITS-1:0]  i_edge_start_x,
    input  logic signed [COORD_BITS-1:0]  i_edge_start_y,
    input  logic signed [COORD_BITS-1:0]  i_edge_end_x,
    input  logic signed [COORD_BITS-1:0]  i_edge_end_y,
    output ssi_pkg::t_flags               o_flags,
    output logic        [2*CW+1:0]        o_ud,
    output logic        [2*CW+1:0]        o_un1,
    output logic        [CW:0]            o_mag_x,
    output logic        [CW:0]            o_mag_y,
    output logic        [CW-1:0]          o_rx0,
    output logic        [CW-1:0]          o_ry0
);
    import ssi_pkg::*;

    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;
    localparam int UW = SW - 1;

    logic signed [DW-1:0] w_rx0, w_ry0, w_rx1, w_ry1, w_ex0, w_ey0, w_ex1, w_ey1;

    // stage 1
    logic signed [DW-1:0] r_drx1, r_dry1, r_dex1, r_dey1, r_wx1, r_wy1;
    logic        [CW-1:0] r_rx01, r_ry01;
    // stage 2
    logic signed [PW-1:0] r_p_dex_dry, r_p_drx_dey, r_p_dey_wx, r_p_dex_wy;
    logic signed [PW-1:0] r_p_dry_wx, r_p_drx_wy;
    logic signed [DW-1:0] r_drx2, r_dry2;
    logic        [CW-1:0] r_rx02, r_ry02;
    // stage 3
    logic signed [SW-1:0] r_den, r_num1, r_num2;
    logic signed [DW-1:0] r_drx3, r_dry3;
    logic        [CW-1:0] r_rx03, r_ry03;
    // stage 4
    t_flags               r_flags;
    logic        [UW-1:0] r_ud, r_un1;
    logic        [DW-1:0] r_mag_x, r_mag_y;
    logic        [CW-1:0] r_rx04, r_ry04;

    logic n_pos_ok, n_neg_ok, n_dpos;

    assign w_rx0 = $signed({i_ray_start_x[CW-1], i_ray_start_x[CW-1:0]});
    assign w_ry0 = $signed({i_ray_start_y[CW-1], i_ray_start_y[CW-1:0]});
    assign w_rx1 = $signed({i_ray_end_x[CW-1], i_ray_end_x[CW-1:0]});
    assign w_ry1 = $signed({i_ray_end_y[CW-1], i_ray_end_y[CW-1:0]});
    assign w_ex0 = $signed({i_edge_start_x[CW-1], i_edge_start_x[CW-1:0]});
    assign w_ey0 = $signed({i_edge_start_y[CW-1], i_edge_start_y[CW-1:0]});
    assign w_ex1 = $signed({i_edge_end_x[CW-1], i_edge_end_x[CW-1:0]});
    assign w_ey1 = $signed({i_edge_end_y[CW-1], i_edge_end_y[CW-1:0]});

    // Sign of D picks which side of zero the numerators must fall on.
    always_comb begin
        n_dpos   = !r_den[SW-1];
        n_pos_ok = !r_num1[SW-1] && (r_num1 <= r_den) && !r_num2[SW-1] && (r_num2 <= r_den);
        n_neg_ok = (r_num1[SW-1] || r_num1 == '0) && (r_num1 >= r_den)
                && (r_num2[SW-1] || r_num2 == '0) && (r_num2 >= r_den);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_drx1 <= w_rx1 - w_rx0;
            r_dry1 <= w_ry1 - w_ry0;
            r_dex1 <= w_ex1 - w_ex0;
            r_dey1 <= w_ey1 - w_ey0;
            r_wx1  <= w_rx0 - w_ex0;
            r_wy1  <= w_ry0 - w_ey0;
            r_rx01 <= i_ray_start_x[CW-1:0];
            r_ry01 <= i_ray_start_y[CW-1:0];

            r_p_dex_dry <= PW'(r_dex1) * PW'(r_dry1);
            r_p_drx_dey <= PW'(r_drx1) * PW'(r_dey1);
            r_p_dey_wx  <= PW'(r_dey1) * PW'(r_wx1);
            r_p_dex_wy  <= PW'(r_dex1) * PW'(r_wy1);
            r_p_dry_wx  <= PW'(r_dry1) * PW'(r_wx1);
            r_p_drx_wy  <= PW'(r_drx1) * PW'(r_wy1);
            r_drx2      <= r_drx1;
            r_dry2      <= r_dry1;
            r_rx02      <= r_rx01;
            r_ry02      <= r_ry01;

            r_den  <= SW'(r_p_drx_dey) - SW'(r_p_dex_dry);
            r_num1 <= SW'(r_p_dex_wy) - SW'(r_p_dey_wx);
            r_num2 <= SW'(r_p_drx_wy) - SW'(r_p_dry_wx);
            r_drx3 <= r_drx2;
            r_dry3 <= r_dry2;
            r_rx03 <= r_rx02;
            r_ry03 <= r_ry02;

            r_flags.hit   <= (r_den != '0) && (n_dpos ? n_pos_ok : n_neg_ok);
            r_flags.neg_x <= r_drx3[DW-1];
            r_flags.neg_y <= r_dry3[DW-1];
            r_ud          <= n_dpos ? UW'(r_den) : UW'(-r_den);
            r_un1         <= n_dpos ? UW'(r_num1) : UW'(-r_num1);
            r_mag_x       <= r_drx3[DW-1] ? DW'(-r_drx3) : DW'(r_drx3);
            r_mag_y       <= r_dry3[DW-1] ? DW'(-r_dry3) : DW'(r_dry3);
            r_rx04        <= r_rx03;
            r_ry04        <= r_ry03;
        end
    end

    assign o_flags = r_flags;
    assign o_ud    = r_ud;
    assign o_un1   = r_un1;
    assign o_mag_x = r_mag_x;
    assign o_mag_y = r_mag_y;
    assign o_rx0   = r_rx04;
    assign o_ry0   = r_ry04;

endmodule

FILE: design/ssi_muldiv.sv
// Pipelined floor(n*m/d), one multiplier bit per stage, lanes sharing n and d.
module ssi_muldiv #(
    parameter int UW = 34,
    parameter int MB = 17
) (
    input  logic                                     i_clk,
    input  logic                                     i_en,
    input  logic [UW-1:0]                            i_n,
    input  logic [UW-1:0]                            i_d,
    input  logic [ssi_pkg::NUM_LANES-1:0][MB-1:0]    i_m,
    output logic [ssi_pkg::NUM_LANES-1:0][MB-1:0]    o_q
);
    import ssi_pkg::*;

    localparam int TW = UW + 2;

    logic [UW-1:0]                 r_n [MB];
    logic [UW-1:0]                 r_d [MB];
    logic [NUM_LANES-1:0][MB-1:0]  r_m [MB];
    logic [NUM_LANES-1:0][UW-1:0]  r_r [MB];
    logic [NUM_LANES-1:0][MB-1:0]  r_q [MB];

    logic [NUM_LANES-1:0][UW-1:0]  n_r [MB];
    logic [NUM_LANES-1:0][MB-1:0]  n_q [MB];

    // Remainder stays below d, so 2r + n < 3d: subtract d or 2d, add 0..2 to q.
    always_comb begin
        logic [UW-1:0] s_n, s_d, s_r;
        logic [MB-1:0] s_m, s_q;
        logic [TW-1:0] s_t, s_d1, s_d2;
        logic          s_ge1, s_ge2;
        for (int k = 0; k < MB; k++) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                s_n  = (k == 0) ? i_n    : r_n[k-1];
                s_d  = (k == 0) ? i_d    : r_d[k-1];
                s_m  = (k == 0) ? i_m[l] : r_m[k-1][l];
                s_r  = (k == 0) ? '0     : r_r[k-1][l];
                s_q  = (k == 0) ? '0     : r_q[k-1][l];
                s_d1 = TW'(s_d);
                s_d2 = s_d1 << 1;
                s_t  = (TW'(s_r) << 1) + (s_m[MB-1-k] ? TW'(s_n) : '0);
                s_ge1 = s_t >= s_d1;
                s_ge2 = s_t >= s_d2;
                n_r[k][l] = UW'(s_t - (s_ge2 ? s_d2 : (s_ge1 ? s_d1 : '0)));
                n_q[k][l] = (s_q << 1) + (s_ge2 ? MB'(2) : (s_ge1 ? MB'(1) : MB'(0)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < MB; k++) begin
                r_n[k] <= (k == 0) ? i_n : r_n[k-1];
                r_d[k] <= (k == 0) ? i_d : r_d[k-1];
                r_m[k] <= (k == 0) ? i_m : r_m[k-1];
                r_r[k] <= n_r[k];
                r_q[k] <= n_q[k];
            end
        end
    end

    assign o_q = r_q[MB-1];

endmodule

FILE: design/segment_segment_intersection.sv
// Parametric segment-segment intersection, fully pipelined.
// Four front stages, one divider stage per quotient bit and one output register;
//   MB = max(CW, FRAC_BITS) + 1 quotient bits, with CW = min(COORD_BITS, 30).
// Throughput: one request per cycle while o_stall is low; a skid register holds one
//   result under i_stall.
// Reset: synchronous, clears every valid bit, including those of the output and skid
//   registers; data registers are not reset.
module segment_segment_intersection #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_BITS-1:0]  i_ray_start_x,
    input  logic signed [COORD_BITS-1:0]  i_ray_start_y,
    input  logic signed [COORD_BITS-1:0]  i_ray_end_x,
    input  logic signed [COORD_BITS-1:0]  i_ray_end_y,
    input  logic signed [COORD_BITS-1:0]  i_edge_start_x,
    input  logic signed [COORD_BITS-1:0]  i_edge_start_y,
    input  logic signed [COORD_BITS-1:0]  i_edge_end_x,
    input  logic signed [COORD_BITS-1:0]  i_edge_end_y,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_hit,
    output logic signed [COORD_BITS-1:0]  o_cross_x,
    output logic signed [COORD_BITS-1:0]  o_cross_y,
    output logic        [FRAC_BITS:0]     o_ray_fraction
);
    import ssi_pkg::*;

    localparam int CW = (COORD_BITS > CW_LIMIT) ? CW_LIMIT : COORD_BITS;
    localparam int DW = CW + 1;
    localparam int UW = 2 * CW + 2;
    localparam int MB = (CW + 1 > FRAC_BITS + 1) ? CW + 1 : FRAC_BITS + 1;
    localparam int FS = 4;
    localparam int NS = FS + MB;

    typedef struct packed {
        logic                 hit;
        logic [CW-1:0]        cx;
        logic [CW-1:0]        cy;
        logic [FRAC_BITS:0]   frac;
    } t_res;

    logic                          w_adv;
    logic                          w_give;
    t_flags                        w_flags;
    logic [UW-1:0]                 w_ud, w_un1;
    logic [DW-1:0]                 w_mag_x, w_mag_y;
    logic [CW-1:0]                 w_rx0, w_ry0;
    logic [NUM_LANES-1:0][MB-1:0]  w_m, w_q;
    logic [CW-1:0]                 w_off_x, w_off_y;
    t_res                          w_res;

    logic [NS-1:0]                 r_vld;
    t_flags                        r_sflg [MB];
    logic [CW-1:0]                 r_srx  [MB];
    logic [CW-1:0]                 r_sry  [MB];
    logic                          r_out_vld, r_skid_vld;
    t_res                          r_out, r_skid;

    // Whole pipeline moves together unless the skid register is occupied.
    assign w_adv   = !r_skid_vld;
    assign w_give  = w_adv && r_vld[NS-1];
    assign o_stall = !w_adv;

    ssi_front #(
        .COORD_BITS (COORD_BITS),
        .CW         (CW)
    ) u_front (
        .i_clk          (i_clk),
        .i_en           (w_adv),
        .i_ray_start_x  (i_ray_start_x),
        .i_ray_start_y  (i_ray_start_y),
        .i_ray_end_x    (i_ray_end_x),
        .i_ray_end_y    (i_ray_end_y),
        .i_edge_start_x (i_edge_start_x),
        .i_edge_start_y (i_edge_start_y),
        .i_edge_end_x   (i_edge_end_x),
        .i_edge_end_y   (i_edge_end_y),
        .o_flags        (w_flags),
        .o_ud           (w_ud),
        .o_un1          (w_un1),
        .o_mag_x        (w_mag_x),
        .o_mag_y        (w_mag_y),
        .o_rx0          (w_rx0),
        .o_ry0          (w_ry0)
    );

    always_comb begin
        w_m         = '0;
        w_m[LANE_X] = MB'(w_mag_x);
        w_m[LANE_Y] = MB'(w_mag_y);
        w_m[LANE_T] = MB'(1'b1) << FRAC_BITS;
    end

    ssi_muldiv #(
        .UW (UW),
        .MB (MB)
    ) u_muldiv (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_n   (w_un1),
        .i_d   (w_ud),
        .i_m   (w_m),
        .o_q   (w_q)
    );

    // Offsets wrap at CW bits; the sum lands between the ray endpoints.
    assign w_off_x = w_q[LANE_X][CW-1:0];
    assign w_off_y = w_q[LANE_Y][CW-1:0];

    always_comb begin
        w_res = '0;
        if (r_sflg[MB-1].hit) begin
            w_res.hit  = 1'b1;
            w_res.cx   = r_sflg[MB-1].neg_x ? r_srx[MB-1] - w_off_x : r_srx[MB-1] + w_off_x;
            w_res.cy   = r_sflg[MB-1].neg_y ? r_sry[MB-1] - w_off_y : r_sry[MB-1] + w_off_y;
            w_res.frac = w_q[LANE_T][FRAC_BITS:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < MB; k++) begin
                r_sflg[k] <= (k == 0) ? w_flags : r_sflg[k-1];
                r_srx[k]  <= (k == 0) ? w_rx0   : r_srx[k-1];
                r_sry[k]  <= (k == 0) ? w_ry0   : r_sry[k-1];
            end
        end
        if (!r_out_vld || !i_stall) begin
            r_out <= r_skid_vld ? r_skid : w_res;
        end else if (w_give) begin
            r_skid <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (w_adv) begin
                r_vld <= {r_vld[NS-2:0], i_valid};
            end
            if (!r_out_vld || !i_stall) begin
                r_out_vld  <= r_skid_vld || w_give;
                r_skid_vld <= 1'b0;
            end else if (w_give) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    assign o_valid        = r_out_vld;
    assign o_hit          = r_out.hit;
    assign o_cross_x      = COORD_BITS'(r_out.cx);
    assign o_cross_y      = COORD_BITS'(r_out.cy);
    assign o_ray_fraction = r_out.frac;

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_cross_x == '0 && o_cross_y == '0 && o_ray_fraction == '0))
        else $error("miss result carries nonzero fields");

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> (o_ray_fraction <= ((FRAC_BITS+1)'(1) << FRAC_BITS)))
        else $error("ray fraction above one");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid holds a result while output is empty");

    a_skid_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && i_stall) |=> ($stable(r_vld) && r_skid_vld))
        else $error("pipeline moved while skid was full");

endmodule

FILE: verif/segment_segment_intersection_checker.sv
// Checker for the segment intersection block: predicts each result and compares it on arrival.
module segment_segment_intersection_checker #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  logic                          i_req_stall,
    input  logic signed [COORD_BITS-1:0]  i_ray_start_x,
    input  logic signed [COORD_BITS-1:0]  i_ray_start_y,
    input  logic signed [COORD_BITS-1:0]  i_ray_end_x,
    input  logic signed [COORD_BITS-1:0]  i_ray_end_y,
    input  logic signed [COORD_BITS-1:0]  i_edge_start_x,
    input  logic signed [COORD_BITS-1:0]  i_edge_start_y,
    input  logic signed [COORD_BITS-1:0]  i_edge_end_x,
    input  logic signed [COORD_BITS-1:0]  i_edge_end_y,
    input  logic                          i_res_valid,
    input  logic                          i_res_stall,
    input  logic                          i_hit,
    input  logic signed [COORD_BITS-1:0]  i_cross_x,
    input  logic signed [COORD_BITS-1:0]  i_cross_y,
    input  logic        [FRAC_BITS:0]     i_ray_fraction,
    output int                            o_mismatch_count,
    output int                            o_pending
);

    typedef struct packed {
        logic                  hit;
        logic [COORD_BITS-1:0] cross_x;
        logic [COORD_BITS-1:0] cross_y;
        logic [FRAC_BITS:0]    fraction;
    } crossing_t;

    crossing_t expected_crossings[$];
    int        mismatches = 0;

    // Exact integer form of the parametric test; longint holds every product at 16 bits.
    function automatic crossing_t predict_crossing(
        input longint rsx, input longint rsy, input longint rex, input longint rey,
        input longint esx, input longint esy, input longint eex, input longint eey
    );
        longint    drx, dry, dex, dey, wx, wy;
        longint    den, n1, n2, qx, qy;
        crossing_t c;
        c   = '0;
        drx = rex - rsx;
        dry = rey - rsy;
        dex = eex - esx;
        dey = eey - esy;
        wx  = rsx - esx;
        wy  = rsy - esy;
        den = dex * (-dry) + drx * dey;
        n1  = (-dey) * wx + dex * wy;
        n2  = (-dry) * wx + drx * wy;
        if (den < 0) begin
            den = -den;
            n1  = -n1;
            n2  = -n2;
        end
        if (den != 0 && n1 >= 0 && n1 <= den && n2 >= 0 && n2 <= den) begin
            // offsets truncate toward zero, so divide the magnitudes
            qx = (n1 * (drx < 0 ? -drx : drx)) / den;
            qy = (n1 * (dry < 0 ? -dry : dry)) / den;
            c.hit      = 1'b1;
            c.cross_x  = COORD_BITS'(rsx + (drx < 0 ? -qx : qx));
            c.cross_y  = COORD_BITS'(rsy + (dry < 0 ? -qy : qy));
            c.fraction = (FRAC_BITS + 1)'((n1 << FRAC_BITS) / den);
        end
        return c;
    endfunction

    always @(posedge i_clk) begin
        crossing_t got;
        crossing_t want;
        if (!i_rst_n) begin
            expected_crossings.delete();
            mismatches = 0;
            o_mismatch_count <= 0;
            o_pending        <= 0;
        end else begin
            if (i_req_valid && !i_req_stall) begin
                expected_crossings.push_back(predict_crossing(
                    longint'(i_ray_start_x), longint'(i_ray_start_y),
                    longint'(i_ray_end_x), longint'(i_ray_end_y),
                    longint'(i_edge_start_x), longint'(i_edge_start_y),
                    longint'(i_edge_end_x), longint'(i_edge_end_y)));
            end
            if (i_res_valid && !i_res_stall) begin
                got = '{i_hit, i_cross_x, i_cross_y, i_ray_fraction};
                if (expected_crossings.size() == 0) begin
                    if (mismatches < 10)
                        $display("ERROR: unexpected result: hit=%0d x=%0d y=%0d t=%0d",
                                 got.hit, $signed(got.cross_x), $signed(got.cross_y),
                                 got.fraction);
                    mismatches = mismatches + 1;
                end else begin
                    want = expected_crossings.pop_front();
                    if (got.hit !== want.hit || got.cross_x !== want.cross_x ||
                        got.cross_y !== want.cross_y || got.fraction !== want.fraction) begin
                        if (mismatches < 10)
                            $display("ERROR: want hit/x/y/t %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                     want.hit, $signed(want.cross_x), $signed(want.cross_y),
                                     want.fraction, got.hit, $signed(got.cross_x),
                                     $signed(got.cross_y), got.fraction);
                        mismatches = mismatches + 1;
                    end
                end
            end
            o_mismatch_count <= mismatches;
            o_pending        <= expected_crossings.size();
        end
    end

endmodule

FILE: verif/segment_segment_intersection_test.sv
// Top of the segment intersection testbench: clock, reset, request and stall stimulus, verdict.
module segment_segment_intersection_test;

    localparam int COORD_BITS     = 16;
    localparam int FRAC_BITS      = 16;
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef enum {PHASE_STEADY, PHASE_SENDER_IDLE, PHASE_RECEIVER_STALL, PHASE_BOTH} phase_e;
    typedef enum {KIND_CROSSING, KIND_PARALLEL, KIND_TOUCH, KIND_NOISE} pair_kind_e;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] ray_start_x;
        logic signed [COORD_BITS-1:0] ray_start_y;
        logic signed [COORD_BITS-1:0] ray_end_x;
        logic signed [COORD_BITS-1:0] ray_end_y;
        logic signed [COORD_BITS-1:0] edge_start_x;
        logic signed [COORD_BITS-1:0] edge_start_y;
        logic signed [COORD_BITS-1:0] edge_end_x;
        logic signed [COORD_BITS-1:0] edge_end_y;
    } seg_pair_t;

    logic                         i_clk          = 1'b0;
    logic                         i_rst_n        = 1'b0;
    logic                         i_valid        = 1'b0;
    logic                         i_stall        = 1'b0;
    logic signed [COORD_BITS-1:0] i_ray_start_x  = '0;
    logic signed [COORD_BITS-1:0] i_ray_start_y  = '0;
    logic signed [COORD_BITS-1:0] i_ray_end_x    = '0;
    logic signed [COORD_BITS-1:0] i_ray_end_y    = '0;
    logic signed [COORD_BITS-1:0] i_edge_start_x = '0;
    logic signed [COORD_BITS-1:0] i_edge_start_y = '0;
    logic signed [COORD_BITS-1:0] i_edge_end_x   = '0;
    logic signed [COORD_BITS-1:0] i_edge_end_y   = '0;
    logic                         o_stall;
    logic                         o_valid;
    logic                         o_hit;
    logic signed [COORD_BITS-1:0] o_cross_x;
    logic signed [COORD_BITS-1:0] o_cross_y;
    logic        [FRAC_BITS:0]    o_ray_fraction;

    int mismatch_count;
    int pending_results;
    int idle_pct      = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int quiet_cycles  = 0;

    always #4 i_clk = ~i_clk;

    segment_segment_intersection #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_ray_start_x  (i_ray_start_x),
        .i_ray_start_y  (i_ray_start_y),
        .i_ray_end_x    (i_ray_end_x),
        .i_ray_end_y    (i_ray_end_y),
        .i_edge_start_x (i_edge_start_x),
        .i_edge_start_y (i_edge_start_y),
        .i_edge_end_x   (i_edge_end_x),
        .i_edge_end_y   (i_edge_end_y),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_hit          (o_hit),
        .o_cross_x      (o_cross_x),
        .o_cross_y      (o_cross_y),
        .o_ray_fraction (o_ray_fraction)
    );

    segment_segment_intersection_checker #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_valid),
        .i_req_stall      (o_stall),
        .i_ray_start_x    (i_ray_start_x),
        .i_ray_start_y    (i_ray_start_y),
        .i_ray_end_x      (i_ray_end_x),
        .i_ray_end_y      (i_ray_end_y),
        .i_edge_start_x   (i_edge_start_x),
        .i_edge_start_y   (i_edge_start_y),
        .i_edge_end_x     (i_edge_end_x),
        .i_edge_end_y     (i_edge_end_y),
        .i_res_valid      (o_valid),
        .i_res_stall      (i_stall),
        .i_hit            (o_hit),
        .i_cross_x        (o_cross_x),
        .i_cross_y        (o_cross_y),
        .i_ray_fraction   (o_ray_fraction),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending_results)
    );

    function automatic int rand_span(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // Full-range coordinate, biased toward the extremes.
    function automatic int rand_coord();
        case ($urandom_range(7))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            3:       return -1;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    function automatic seg_pair_t pair_of(int rsx, int rsy, int rex, int rey,
                                          int esx, int esy, int eex, int eey);
        seg_pair_t s;
        s = '{COORD_BITS'(rsx), COORD_BITS'(rsy), COORD_BITS'(rex), COORD_BITS'(rey),
              COORD_BITS'(esx), COORD_BITS'(esy), COORD_BITS'(eex), COORD_BITS'(eey)};
        return s;
    endfunction

    function automatic seg_pair_t random_pair();
        seg_pair_t  s;
        pair_kind_e kind;
        int         roll, px, py, span, rdx, rdy, edx, edy, m, n, a, b, ox, oy;
        roll = $urandom_range(99);
        if (roll < 55)      kind = KIND_CROSSING;
        else if (roll < 70) kind = KIND_PARALLEL;
        else if (roll < 80) kind = KIND_TOUCH;
        else                kind = KIND_NOISE;
        case (kind)
            KIND_CROSSING: begin
                // both segments pass through a common point, then maybe get nudged off it
                px   = rand_span(-16384, 16383);
                py   = rand_span(-16384, 16383);
                span = $urandom_range(1) ? 63 : 2047;
                rdx  = rand_span(-span - 1, span);
                rdy  = rand_span(-span - 1, span);
                edx  = rand_span(-span - 1, span);
                edy  = rand_span(-span - 1, span);
                m    = rand_span(0, 4);
                n    = rand_span(0, 4);
                a    = rand_span(0, 4);
                b    = rand_span(0, 4);
                s = pair_of(px - m * rdx, py - m * rdy, px + n * rdx, py + n * rdy,
                            px - a * edx, py - a * edy, px + b * edx, py + b * edy);
                if ($urandom_range(3) == 0) begin
                    s.edge_end_x = COORD_BITS'(s.edge_end_x + rand_span(-3, 3));
                    s.ray_end_y  = COORD_BITS'(s.ray_end_y + rand_span(-3, 3));
                end
            end
            KIND_PARALLEL: begin
                px  = rand_span(-4096, 4095);
                py  = rand_span(-4096, 4095);
                rdx = rand_span(-4096, 4095);
                rdy = rand_span(-4096, 4095);
                ox  = $urandom_range(1) ? 0 : rand_span(-64, 64);
                oy  = $urandom_range(1) ? 0 : rand_span(-64, 64);
                a   = rand_span(-2, 2);
                b   = rand_span(-2, 2);
                s = pair_of(px, py, px + rdx, py + rdy,
                            px + ox + a * rdx, py + oy + a * rdy,
                            px + ox + (a + b) * rdx, py + oy + (a + b) * rdy);
            end
            KIND_TOUCH: begin
                s = pair_of(rand_span(-16384, 16383), rand_span(-16384, 16383),
                            rand_span(-16384, 16383), rand_span(-16384, 16383),
                            0, 0, rand_span(-16384, 16383), rand_span(-16384, 16383));
                if ($urandom_range(1)) begin
                    s.edge_start_x = s.ray_end_x;
                    s.edge_start_y = s.ray_end_y;
                end else begin
                    s.edge_start_x = s.ray_start_x;
                    s.edge_start_y = s.ray_start_y;
                end
            end
            default: begin
                s = pair_of(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                            rand_coord(), rand_coord(), rand_coord(), rand_coord());
            end
        endcase
        return s;
    endfunction

    task automatic set_phase(phase_e ph);
        case (ph)
            PHASE_STEADY:         begin idle_pct = 0;  stall_pct = 0;  end
            PHASE_SENDER_IDLE:    begin idle_pct = 57; stall_pct = 0;  end
            PHASE_RECEIVER_STALL: begin idle_pct = 0;  stall_pct = 57; end
            default:              begin idle_pct = 8;  stall_pct = 8;  end
        endcase
    endtask

    task automatic send_request(seg_pair_t s);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_ray_start_x  <= s.ray_start_x;
        i_ray_start_y  <= s.ray_start_y;
        i_ray_end_x    <= s.ray_end_x;
        i_ray_end_y    <= s.ray_end_y;
        i_edge_start_x <= s.edge_start_x;
        i_edge_start_y <= s.edge_start_y;
        i_edge_end_x   <= s.edge_end_x;
        i_edge_end_y   <= s.edge_end_y;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Let the pending count take in the last accepted request before polling it.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
    endtask

    // Receiver side: random stalls, plus a long hold-off on demand.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_requests) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_served = hold_served + 1;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        set_phase(PHASE_STEADY);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero-length segments, plain hit, misses on each side, parallel and collinear
        send_request(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
        send_request(pair_of(0, 0, 160, 0, 80, -80, 80, 80));
        send_request(pair_of(0, 0, 160, 0, 200, -80, 200, 80));
        send_request(pair_of(0, 0, 160, 0, -40, -80, -40, 80));
        send_request(pair_of(0, 0, 160, 0, 80, 10, 80, 80));
        send_request(pair_of(0, 0, 160, 0, 0, 16, 160, 16));
        send_request(pair_of(0, 0, 160, 0, 40, 0, 200, 0));
        // endpoint touches: ray start, ray end, edge start, edge end
        send_request(pair_of(0, 0, 160, 0, 0, -80, 0, 80));
        send_request(pair_of(0, 0, 160, 0, 160, -80, 160, 80));
        send_request(pair_of(0, 0, 160, 0, 80, 0, 80, 80));
        send_request(pair_of(0, 0, 160, 0, 80, -80, 80, 0));
        // negative denominator
        send_request(pair_of(0, 0, 160, 0, 80, 80, 80, -80));
        // full-range diagonals and axes
        send_request(pair_of(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        send_request(pair_of(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
        send_request(pair_of(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768));
        send_request(pair_of(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
        send_request(pair_of(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        // truncation toward zero on negative offsets, and of the fraction
        send_request(pair_of(0, 0, -3, -7, -1, -10, -1, 10));
        send_request(pair_of(0, 0, 3, 0, 1, -1, 1, 1));
        // ray shrunk to a point lying on the edge
        send_request(pair_of(5, 5, 5, 5, 0, 0, 10, 10));
        wait_for_results();

        // fill the pipe against a held-off receiver
        hold_requests = hold_requests + 1;
        repeat (40) send_request(random_pair());
        wait_for_results();

        for (int round = 0; round < 2; round++) begin
            for (int ph = 0; ph < 4; ph++) begin
                set_phase(phase_e'(ph));
                repeat (100) send_request(random_pair());
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
design/ssi_pkg.sv
design/ssi_front.sv
design/ssi_muldiv.sv
design/segment_segment_intersection.sv
verif/segment_segment_intersection_checker.sv
verif/segment_segment_intersection_test.sv
